@@ src/wdbd_pkg.sv @@
// ----------------------------------------------------------------------------
// wdbd_pkg
// Shared types and constants for the WAV deframer / boxcar decimator.
// ----------------------------------------------------------------------------
package wdbd_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       is_status;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CKHDR,
    PH_BODY,
    PH_PAD,
    PH_HALT
  } parse_phase_t;

  // Result slot occupancy, controller state
  typedef enum logic [1:0] {
    RS_EMPTY,
    RS_SAMPLE,
    RS_STATUS,
    RS_BOTH
  } res_state_t;

  typedef struct packed {
    logic load;         // accept the current input item
    logic show_status;  // output register presents the status result
  } ctrl_cmd_t;

  typedef struct packed {
    logic smp_emit;     // current item closes a sample group
    logic sts_emit;     // current item is the last byte of the file
  } dp_stat_t;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_MISSING   = 3'd4;

  // Tags, little-endian: byte i sits at bits [8i+7:8i]
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
  localparam logic [31:0] FMT_TAG  = 32'h2074_6D66;
  localparam logic [31:0] DATA_TAG = 32'h6174_6164;

  localparam logic [5:0] MIN_FILE = 6'd44;
  localparam logic [4:0] FMT_MIN  = 5'd16;

  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 19;

  // PCM, mono, 8 bits: check of the fixed bytes of a fmt body
  function automatic logic fmt_byte_ok(input logic [4:0] idx, input logic [7:0] b);
    logic ok;
    unique case (idx)
      5'd0, 5'd2:  ok = (b == 8'd1);
      5'd1, 5'd3:  ok = (b == 8'd0);
      5'd14:       ok = (b == 8'd8);
      5'd15:       ok = (b == 8'd0);
      default:     ok = 1'b1;
    endcase
    return ok;
  endfunction

  // ceil(2^18 / (fm1 + 1)); exact truncating quotient for sums below 4096
  function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] fm1);
    logic [RECIP_W-1:0] r;
    unique case (fm1)
      4'd0:  r = 19'd262144;
      4'd1:  r = 19'd131072;
      4'd2:  r = 19'd87382;
      4'd3:  r = 19'd65536;
      4'd4:  r = 19'd52429;
      4'd5:  r = 19'd43691;
      4'd6:  r = 19'd37450;
      4'd7:  r = 19'd32768;
      4'd8:  r = 19'd29128;
      4'd9:  r = 19'd26215;
      4'd10: r = 19'd23832;
      4'd11: r = 19'd21846;
      4'd12: r = 19'd20165;
      4'd13: r = 19'd18725;
      4'd14: r = 19'd17477;
      4'd15: r = 19'd16384;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

@@ src/wdbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// wdbd_ctrl
// Handshake controller: tracks which result slots are held and when the
// next input byte may be taken.
// ----------------------------------------------------------------------------
module wdbd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  wdbd_pkg::dp_stat_t  stat,
  output wdbd_pkg::ctrl_cmd_t cmd
);
  import wdbd_pkg::*;

  res_state_t state_r, state_nxt;
  res_state_t left;
  logic       take;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    out_valid = (state_r != RS_EMPTY);
    take      = out_valid && out_ready;

    // slots still held after this cycle's output transfer
    unique case (state_r)
      RS_EMPTY:  left = RS_EMPTY;
      RS_SAMPLE: left = take ? RS_EMPTY  : RS_SAMPLE;
      RS_STATUS: left = take ? RS_EMPTY  : RS_STATUS;
      RS_BOTH:   left = take ? RS_STATUS : RS_BOTH;
    endcase

    in_ready = (left == RS_EMPTY);
    accept   = in_valid && in_ready;

    state_nxt = left;
    if (accept) begin
      unique case ({stat.smp_emit, stat.sts_emit})
        2'b00: state_nxt = RS_EMPTY;
        2'b10: state_nxt = RS_SAMPLE;
        2'b01: state_nxt = RS_STATUS;
        2'b11: state_nxt = RS_BOTH;
      endcase
    end

    cmd.load        = accept;
    cmd.show_status = (state_r == RS_STATUS);
  end

endmodule

@@ src/wdbd_dpath.sv @@
// ----------------------------------------------------------------------------
// wdbd_dpath
// Parser and decimator datapath: walks RIFF chunks, checks fmt, averages
// data bytes and holds the sample and status results.
// ----------------------------------------------------------------------------
module wdbd_dpath #(
  parameter int MAX_FACTOR = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wdbd_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  wdbd_pkg::ctrl_cmd_t cmd,
  output wdbd_pkg::dp_stat_t  stat,
  output wdbd_pkg::out_item_t out_data
);
  import wdbd_pkg::*;

  localparam int F_W    = $clog2(MAX_FACTOR + 1);
  localparam int SUM_W  = $clog2(MAX_FACTOR * 255 + 1);
  localparam int PROD_W = SUM_W + RECIP_W;

  parse_phase_t      phase_r, phase_nxt;
  logic [3:0]        fi_r, fi_nxt;
  logic [31:0]       tag_r, tag_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [4:0]        fmti_r, fmti_nxt;
  logic              fmt_ok_r, fmt_ok_nxt;
  logic              data_r, data_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [5:0]        bytes_r, bytes_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [F_W-1:0]    cnt_r, cnt_nxt;
  logic [3:0]        factor_r;
  logic [7:0]        sample_r;
  logic [2:0]        status_r;

  logic [7:0]        b;
  logic [F_W-1:0]    eff_f;
  logic [F_W-1:0]    cnt_inc;
  logic [SUM_W-1:0]  sum_add;
  logic [PROD_W-1:0] prod;
  logic [31:0]       len_full;
  logic [2:0]        sts_code;
  logic              smp_emit;

  assign b = in_data.file_byte;

  // clamp the factor into 1..MAX_FACTOR
  always_comb begin
    if (factor_r == 4'd0) begin
      eff_f = F_W'(1);
    end else if (int'(factor_r) > MAX_FACTOR) begin
      eff_f = F_W'(MAX_FACTOR);
    end else begin
      eff_f = F_W'(factor_r);
    end
  end

  assign cnt_inc  = cnt_r + F_W'(1);
  assign sum_add  = sum_r + SUM_W'(b);
  assign prod     = PROD_W'(sum_add) * PROD_W'(recip_of(4'(eff_f - F_W'(1))));
  assign len_full = {b, rem_r[23:0]};

  always_comb begin
    phase_nxt  = phase_r;
    fi_nxt     = fi_r;
    tag_nxt    = tag_r;
    rem_nxt    = rem_r;
    fmti_nxt   = fmti_r;
    fmt_ok_nxt = fmt_ok_r;
    data_nxt   = data_r;
    err_nxt    = err_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    smp_emit   = 1'b0;
    sts_code   = ST_OK;
    bytes_nxt  = (bytes_r < MIN_FILE) ? bytes_r + 6'd1 : bytes_r;

    unique case (phase_r)
      PH_HEADER: begin
        if ((fi_r < 4'd4 && b != RIFF_TAG[{fi_r[1:0], 3'b000} +: 8]) ||
            (fi_r >= 4'd8 && b != WAVE_TAG[{fi_r[1:0], 3'b000} +: 8])) begin
          err_nxt   = ST_BAD_HDR;
          phase_nxt = PH_HALT;
        end else if (fi_r == 4'd11) begin
          phase_nxt = PH_CKHDR;
          fi_nxt    = 4'd0;
        end else begin
          fi_nxt = fi_r + 4'd1;
        end
      end
      PH_CKHDR: begin
        if (!fi_r[2]) begin
          if (fi_r[1:0] == 2'd0) begin
            tag_nxt = {24'd0, b};
          end else begin
            tag_nxt[{fi_r[1:0], 3'b000} +: 8] = b;
          end
        end else begin
          if (fi_r[1:0] == 2'd0) begin
            rem_nxt = {24'd0, b};
          end else begin
            rem_nxt[{fi_r[1:0], 3'b000} +: 8] = b;
          end
        end
        if (fi_r == 4'd7) begin
          fmti_nxt = (tag_r == FMT_TAG && len_full >= 32'(FMT_MIN)) ? 5'd0 : FMT_MIN;
          if (tag_r == DATA_TAG && fmt_ok_r) begin
            data_nxt = 1'b1;
          end
          sum_nxt = '0;
          cnt_nxt = '0;
          if (len_full == 32'd0) begin
            phase_nxt = PH_CKHDR;
            fi_nxt    = 4'd0;
          end else begin
            phase_nxt = PH_BODY;
            fi_nxt    = {3'd0, len_full[0]};  // odd length: pad byte follows
          end
        end else begin
          fi_nxt = fi_r + 4'd1;
        end
      end
      PH_BODY: begin
        if (fmti_r < FMT_MIN && !fmt_byte_ok(fmti_r, b)) begin
          err_nxt   = ST_BAD_FMT;
          phase_nxt = PH_HALT;
        end else begin
          if (fmti_r < FMT_MIN) begin
            fmti_nxt = fmti_r + 5'd1;
            if (fmti_r == FMT_MIN - 5'd1) begin
              fmt_ok_nxt = 1'b1;
            end
          end else if (tag_r == DATA_TAG && data_r && fmt_ok_r) begin
            if (cnt_inc >= eff_f) begin
              smp_emit = 1'b1;
              sum_nxt  = '0;
              cnt_nxt  = '0;
            end else begin
              sum_nxt = sum_add;
              cnt_nxt = cnt_inc;
            end
          end
          rem_nxt = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            // end of chunk: drop any partial group
            sum_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = (fi_r != 4'd0) ? PH_PAD : PH_CKHDR;
            fi_nxt    = 4'd0;
          end
        end
      end
      PH_PAD: begin
        phase_nxt = PH_CKHDR;
        fi_nxt    = 4'd0;
      end
      PH_HALT: begin
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    if (in_data.end_of_file) begin
      priority if (bytes_nxt < MIN_FILE) begin
        sts_code = ST_SHORT;
      end else if (err_nxt != ST_OK) begin
        sts_code = err_nxt;
      end else if (!fmt_ok_nxt || !data_nxt) begin
        sts_code = ST_MISSING;
      end else begin
        sts_code = ST_OK;
      end
      // return to the start of a new file
      phase_nxt  = PH_HEADER;
      fi_nxt     = 4'd0;
      tag_nxt    = '0;
      rem_nxt    = '0;
      fmti_nxt   = 5'd0;
      fmt_ok_nxt = 1'b0;
      data_nxt   = 1'b0;
      err_nxt    = ST_OK;
      bytes_nxt  = 6'd0;
      sum_nxt    = '0;
      cnt_nxt    = '0;
    end
  end

  assign stat.smp_emit = smp_emit;
  assign stat.sts_emit = in_data.end_of_file;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      fi_r     <= 4'd0;
      tag_r    <= '0;
      rem_r    <= '0;
      fmti_r   <= 5'd0;
      fmt_ok_r <= 1'b0;
      data_r   <= 1'b0;
      err_r    <= ST_OK;
      bytes_r  <= 6'd0;
      sum_r    <= '0;
      cnt_r    <= '0;
      factor_r <= 4'd1;
    end else begin
      if (cmd.load) begin
        phase_r  <= phase_nxt;
        fi_r     <= fi_nxt;
        tag_r    <= tag_nxt;
        rem_r    <= rem_nxt;
        fmti_r   <= fmti_nxt;
        fmt_ok_r <= fmt_ok_nxt;
        data_r   <= data_nxt;
        err_r    <= err_nxt;
        bytes_r  <= bytes_nxt;
        sum_r    <= sum_nxt;
        cnt_r    <= cnt_nxt;
      end
      if (cfg_we) begin
        factor_r <= cfg_data;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load && smp_emit) begin
      sample_r <= prod[RECIP_SHIFT +: 8];
    end
    if (cmd.load && in_data.end_of_file) begin
      status_r <= sts_code;
    end
  end

  always_comb begin
    out_data.sample    = cmd.show_status ? 8'd0 : sample_r;
    out_data.is_status = cmd.show_status;
    out_data.status    = cmd.show_status ? status_r : ST_OK;
    out_data.last      = cmd.show_status;
  end

endmodule

@@ src/wav_deframe_boxcar_decimate.sv @@
// ----------------------------------------------------------------------------
// wav_deframe_boxcar_decimate
// RIFF/WAVE byte-stream parser with boxcar decimation of 8-bit PCM data.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one file byte per transfer, end_of_file marks the last byte.
//   out_* : averaged samples (is_status 0), then one status result with
//           last set after the end-of-file byte.
//   cfg_* : writes the 4-bit decimation factor (reset 1); write only while
//           no item is in flight. cfg_ready is always high.
// Timing: a result appears in the output register in the cycle after the byte
//   that caused it. Throughput: one byte per cycle while out_ready is high;
//   the end-of-file byte that also closes a group yields two results and
//   holds off the next byte until the status result goes out.
// Stall: two result slots sit behind the output; in_ready drops while a
//   result is still held after the current output transfer.
// Reset: synchronous, active low; the parser returns to the file header
//   and the result slots empty. The parser also restarts after every
//   end-of-file byte.
// ----------------------------------------------------------------------------
module wav_deframe_boxcar_decimate #(
  parameter int MAX_FACTOR = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wdbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wdbd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  import wdbd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  wdbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wdbd_dpath #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the WAV deframer with boxcar decimation.
// Streams whole RIFF/WAVE files byte by byte (good, truncated, corrupted and
// noise files), tracks the parser in a local model and compares every sample
// and status result against it, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import wdbd_pkg::*;

  localparam int MAX_FACTOR  = 8;
  localparam int QUIET_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  wav_deframe_boxcar_decimate #(.MAX_FACTOR(MAX_FACTOR)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser model state
  parse_phase_t phase;
  int           fidx;
  logic [31:0]  tag;
  logic [32:0]  size_left;
  int           fmt_pos;
  bit           fmt_good;
  bit           data_good;
  logic [2:0]   err_code;
  int           byte_count;
  int           acc;
  int           grp;
  bit           pad_due;
  logic [3:0]   factor;

  out_item_t    decoded_q[$];
  logic [7:0]   fbytes[$];

  int           mismatches;
  int           bytes_sent;
  int           files_done;
  int           samples_checked;
  int           statuses_checked;
  int           quiet_cycles;
  logic [15:0]  factors_hit;
  bit           jitter_on;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  task automatic restart_parse();
    phase      = PH_HEADER;
    fidx       = 0;
    tag        = '0;
    size_left  = '0;
    fmt_pos    = 0;
    fmt_good   = 1'b0;
    data_good  = 1'b0;
    err_code   = ST_OK;
    byte_count = 0;
    acc        = 0;
    grp        = 0;
    pad_due    = 1'b0;
  endtask

  task automatic stop_parse(input logic [2:0] code);
    err_code = code;
    phase    = PH_HALT;
  endtask

  // PCM format tag 1, one channel, 8 bits per sample; other fmt bytes are free
  function automatic bit pcm_byte_fits(input int pos, input logic [7:0] b);
    case (pos)
      0, 2:     return b == 8'd1;
      1, 3, 15: return b == 8'd0;
      14:       return b == 8'd8;
      default:  return 1'b1;
    endcase
  endfunction

  task automatic decode_byte(input in_item_t item);
    logic [7:0] b;
    logic [2:0] code;
    int         f;
    bit         bad_fmt;
    b       = item.file_byte;
    bad_fmt = 1'b0;
    if (byte_count < MIN_FILE) byte_count++;
    case (phase)
      PH_HEADER: begin
        if (fidx < 4 && b != RIFF_TAG[8*fidx +: 8]) stop_parse(ST_BAD_HDR);
        if (fidx >= 8 && fidx < 12 && b != WAVE_TAG[8*(fidx-8) +: 8]) stop_parse(ST_BAD_HDR);
        if (phase == PH_HEADER) begin
          fidx++;
          if (fidx == 12) begin
            phase = PH_CKHDR;
            fidx  = 0;
          end
        end
      end
      PH_CKHDR: begin
        if (fidx < 4) begin
          tag[8*fidx +: 8] = b;
        end else begin
          if (fidx == 4) size_left = '0;
          size_left[8*(fidx-4) +: 8] = b;
        end
        fidx++;
        if (fidx == 8) begin
          fmt_pos = (tag == FMT_TAG && size_left >= FMT_MIN) ? 0 : int'(FMT_MIN);
          if (tag == DATA_TAG && fmt_good) data_good = 1'b1;
          acc     = 0;
          grp     = 0;
          pad_due = size_left[0];
          fidx    = 0;
          phase   = (size_left == 0) ? PH_CKHDR : PH_BODY;
        end
      end
      PH_BODY: begin
        if (fmt_pos < FMT_MIN) begin
          if (!pcm_byte_fits(fmt_pos, b)) begin
            stop_parse(ST_BAD_FMT);
            bad_fmt = 1'b1;
          end else begin
            fmt_pos++;
            if (fmt_pos == FMT_MIN) fmt_good = 1'b1;
          end
        end else if (tag == DATA_TAG && data_good && fmt_good) begin
          f = (factor == 0) ? 1 : (factor > MAX_FACTOR) ? MAX_FACTOR : int'(factor);
          acc += b;
          grp++;
          if (grp >= f) begin
            decoded_q.push_back('{sample: 8'(acc / f), is_status: 1'b0,
                                  status: ST_OK, last: 1'b0});
            acc = 0;
            grp = 0;
          end
        end
        if (!bad_fmt) begin
          size_left = size_left - 1;
          if (size_left == 0) begin
            // drop any partial group at the end of the chunk
            acc   = 0;
            grp   = 0;
            phase = pad_due ? PH_PAD : PH_CKHDR;
            fidx  = 0;
          end
        end
      end
      PH_PAD: begin
        phase = PH_CKHDR;
        fidx  = 0;
      end
      default: ;
    endcase

    if (item.end_of_file) begin
      if (byte_count < MIN_FILE)       code = ST_SHORT;
      else if (err_code != ST_OK)      code = err_code;
      else if (!fmt_good || !data_good) code = ST_MISSING;
      else                              code = ST_OK;
      decoded_q.push_back('{sample: 8'd0, is_status: 1'b1, status: code, last: 1'b1});
      files_done++;
      restart_parse();
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: track accepted bytes and register writes, check each result
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    mismatches++;
    // keep the log short on a badly broken build
    if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      factor = 4'd1;
      restart_parse();
    end else begin
      if (in_valid && in_ready) decode_byte(in_data);
      if (cfg_valid && cfg_ready) begin
        factor = cfg_data;
        factors_hit[cfg_data] = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result sample=%h is_status=%b status=%0d last=%b",
                                  out_data.sample, out_data.is_status, out_data.status,
                                  out_data.last));
        end else begin
          want = decoded_q.pop_front();
          if (want.is_status) statuses_checked++;
          else samples_checked++;
          if (out_data.sample !== want.sample)
            note_mismatch($sformatf("sample %h, want %h", out_data.sample, want.sample));
          if (out_data.is_status !== want.is_status)
            note_mismatch($sformatf("is_status %b, want %b", out_data.is_status, want.is_status));
          if (out_data.status !== want.status)
            note_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
          if (out_data.last !== want.last)
            note_mismatch($sformatf("last %b, want %b", out_data.last, want.last));
        end
      end
    end
  end

  // Stall the result side at random while jitter is on
  always @(negedge clk) begin
    out_ready <= jitter_on ? ($urandom_range(99) >= 37) : 1'b1;
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, decoded_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eof);
    in_item_t item;
    item.file_byte   = b;
    item.end_of_file = eof;
    if (jitter_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 37);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_bytes(input int first, input int count, input bit eof_at_end);
    for (int i = first; i < first + count; i++)
      send_byte(fbytes[i], eof_at_end && (i == first + count - 1));
  endtask

  // Send the built file, cut after keep bytes when keep is nonzero
  task automatic send_file(input int keep);
    int n;
    n = fbytes.size();
    if (keep > 0 && keep < n) n = keep;
    send_bytes(0, n, 1'b1);
    fbytes.delete();
  endtask

  // Hold the input until every pending result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_factor(input logic [3:0] f);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // File builders
  // --------------------------------------------------------------------------
  task automatic put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) fbytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_riff();
    put_le32(RIFF_TAG);
    put_le32($urandom);
    put_le32(WAVE_TAG);
  endtask

  // Chunk with a declared length and nbody random body bytes; pad when complete
  task automatic put_chunk(input logic [31:0] ck, input logic [31:0] len, input int nbody);
    put_le32(ck);
    put_le32(len);
    repeat (nbody) fbytes.push_back(8'($urandom_range(255)));
    if (nbody == len && len[0]) fbytes.push_back(8'($urandom_range(255)));
  endtask

  // fmt chunk for mono 8-bit PCM; corrupt breaks one of the fixed bytes
  task automatic put_fmt(input int len, input bit corrupt);
    int start;
    int pos;
    put_le32(FMT_TAG);
    put_le32(len);
    start = fbytes.size();
    for (int i = 0; i < len; i++) begin
      case (i)
        0, 2:    fbytes.push_back(8'd1);
        1, 3:    fbytes.push_back(8'd0);
        14:      fbytes.push_back(8'd8);
        15:      fbytes.push_back(8'd0);
        default: fbytes.push_back(8'($urandom_range(255)));
      endcase
    end
    if (len % 2) fbytes.push_back(8'($urandom_range(255)));
    if (corrupt) begin
      pos = $urandom_range(5);
      pos = (pos < 4) ? pos : pos + 10;
      fbytes[start + pos] ^= 8'($urandom_range(1, 255));
    end
  endtask

  task automatic corrupt_header();
    int pos;
    pos = $urandom_range(7);
    pos = (pos < 4) ? pos : pos + 4;
    fbytes[pos] ^= 8'($urandom_range(1, 255));
  endtask

  task automatic build_random_file();
    int roll;
    int len;
    int nch;
    roll = $urandom_range(99);
    if (roll < 5) begin
      repeat ($urandom_range(1, 70)) fbytes.push_back(8'($urandom_range(255)));
    end else begin
      put_riff();
      if (roll < 12) begin
        len = $urandom_range(0, 9);
        put_chunk(DATA_TAG, len, len);
      end else if (roll < 18) begin
        len = $urandom_range(0, 15);
        put_chunk(FMT_TAG, len, len);
      end
      if (roll < 90) put_fmt($urandom_range(16, 21), roll >= 80 && roll < 86);
      nch = $urandom_range(0, 3);
      repeat (nch) begin
        if ($urandom_range(3) == 0) begin
          len = $urandom_range(0, 9);
          put_chunk($urandom, len, len);
        end else begin
          len = $urandom_range(0, 40);
          put_chunk(DATA_TAG, len, len);
        end
      end
      // data chunk that runs past the end of the file
      if (roll >= 86 && roll < 93) put_chunk(DATA_TAG, $urandom, $urandom_range(0, 20));
      if (roll >= 93) corrupt_header();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_length_and_tags();
    // run this whole test with no idling on either side
    jitter_on = 1'b0;
    fbytes.push_back(8'h52);
    send_file(0);
    // 44-byte file: cut one byte short, then whole with an empty data chunk
    put_riff(); put_fmt(16, 1'b0); put_chunk(DATA_TAG, 0, 0);
    send_file(43);
    put_riff(); put_fmt(16, 1'b0); put_chunk(DATA_TAG, 0, 0);
    send_file(0);
    put_riff(); put_fmt(16, 1'b0); put_chunk(DATA_TAG, 0, 0);
    fbytes[0] ^= 8'h80;
    send_file(0);
    put_riff(); put_fmt(16, 1'b0); put_chunk(DATA_TAG, 0, 0);
    fbytes[11] ^= 8'h01;
    send_file(0);
    jitter_on = 1'b1;
  endtask

  task automatic test_fmt_rules();
    // sample extremes at factor 1
    put_riff(); put_fmt(16, 1'b0);
    put_le32(DATA_TAG); put_le32(3);
    fbytes.push_back(8'h00); fbytes.push_back(8'hFF); fbytes.push_back(8'h80);
    fbytes.push_back(8'hFF);
    send_file(0);
    put_riff(); put_fmt(18, 1'b1); put_chunk(DATA_TAG, 4, 4);
    send_file(0);
    // fmt under 16 bytes is skipped, so the data after it is too
    put_riff(); put_chunk(FMT_TAG, 15, 15); put_chunk(DATA_TAG, 6, 6);
    send_file(0);
    put_riff(); put_chunk(DATA_TAG, 5, 5); put_fmt(16, 1'b0);
    send_file(0);
    put_riff(); put_fmt(20, 1'b0); put_chunk(32'h5453_494C, 4, 4);
    send_file(0);
  endtask

  task automatic test_factor_sweep();
    logic [3:0] sweep [6] = '{4'd0, 4'd3, 4'd7, 4'd8, 4'd9, 4'd15};
    int len;
    // one file, one data chunk per factor value
    drain();
    put_riff(); put_fmt(16, 1'b0);
    send_bytes(0, fbytes.size(), 1'b0);
    fbytes.delete();
    foreach (sweep[i]) begin
      drain();
      write_factor(sweep[i]);
      len = $urandom_range(8, 10);
      put_chunk(DATA_TAG, len, len);
      send_bytes(0, fbytes.size(), i == 5);
      fbytes.delete();
    end
  endtask

  task automatic test_factor_change_midgroup();
    drain();
    write_factor(4'd4);
    put_riff(); put_fmt(16, 1'b0); put_chunk(DATA_TAG, 24, 24);
    // stop two samples into a group, then shrink the factor to that count
    send_bytes(0, 46, 1'b0);
    drain();
    write_factor(4'd2);
    send_bytes(46, 5, 1'b0);
    drain();
    write_factor(4'd7);
    send_bytes(51, fbytes.size() - 51, 1'b1);
    fbytes.delete();
  endtask

  task automatic test_random_files();
    int start;
    int keep;
    start = bytes_sent;
    while (bytes_sent - start < 60) begin
      if ($urandom_range(3) == 0) begin
        drain();
        write_factor(4'($urandom_range(15)));
      end
      build_random_file();
      keep = ($urandom_range(9) == 0) ? $urandom_range(1, fbytes.size()) : 0;
      send_file(keep);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_ready        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_data         = 4'd0;
    mismatches       = 0;
    bytes_sent       = 0;
    files_done       = 0;
    samples_checked  = 0;
    statuses_checked = 0;
    quiet_cycles     = 0;
    factors_hit      = 16'h0002;
    jitter_on        = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_length_and_tags();
    test_fmt_rules();
    test_factor_sweep();
    test_factor_change_midgroup();
    test_random_files();
    drain();

    $display("Streamed %0d bytes in %0d files; factor values written: %b",
             bytes_sent, files_done, factors_hit);
    $display("Compared %0d samples and %0d status results", samples_checked,
             statuses_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
